@@ hw/rtl/ntg_pkg.sv @@
// ----------------------------------------------------------------------------
// ntg_pkg
// Shared types and note tables for the square-wave note tone generator.
// ----------------------------------------------------------------------------
package ntg_pkg;

	localparam int unsigned NOTE_COUNT = 25;
	localparam int unsigned IDX_W      = 5;
	localparam int unsigned DUR_W      = 3;
	localparam int unsigned HALF_W     = 6;
	localparam int unsigned PERIODS_W  = 9;

	localparam logic [IDX_W-1:0]  REST_INDEX = 5'd24;
	localparam logic [HALF_W-1:0] REST_TICKS = 6'd60;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [DUR_W-1:0] {
		DUR_WHOLE       = 3'd0,
		DUR_DOTTED_HALF = 3'd1,
		DUR_HALF        = 3'd2,
		DUR_QUARTER     = 3'd3,
		DUR_EIGHTH      = 3'd4
	} duration_t;

	// half-period of each note in ticks, rest last
	localparam logic [HALF_W-1:0] HALF_TAB [NOTE_COUNT] = '{
		6'd23, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd14, 6'd13, 6'd12,
		6'd46, 6'd42, 6'd40, 6'd38, 6'd36, 6'd34, 6'd32, 6'd30, 6'd29, 6'd28, 6'd26, 6'd24,
		6'd30
	};

	// note frequencies in millihertz
	localparam logic [31:0] MILLI_HZ_TAB [NOTE_COUNT] = '{
		32'd220000, 32'd233080, 32'd246940, 32'd261630, 32'd277180, 32'd293660,
		32'd311130, 32'd329630, 32'd349230, 32'd369990, 32'd392000, 32'd415300,
		32'd110000, 32'd116540, 32'd123470, 32'd130815, 32'd138590, 32'd146830,
		32'd155565, 32'd164815, 32'd174615, 32'd184995, 32'd196000, 32'd207650,
		32'd166660
	};

endpackage

@@ hw/rtl/ntg_req_if.sv @@
// ----------------------------------------------------------------------------
// ntg_req_if
// Request channel of the tone generator: opcode, note and duration.
// ----------------------------------------------------------------------------
interface ntg_req_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [ntg_pkg::IDX_W-1:0]     note_index;
	logic [ntg_pkg::DUR_W-1:0]     duration_code;

	modport source (output valid, output opcode, output note_index, output duration_code,
		input ready);
	modport sink (input valid, input opcode, input note_index, input duration_code,
		output ready);
endinterface

@@ hw/rtl/ntg_res_if.sv @@
// ----------------------------------------------------------------------------
// ntg_res_if
// Result channel of the tone generator: speaker level and note status.
// ----------------------------------------------------------------------------
interface ntg_res_if;
	logic valid;
	logic ready;
	logic speaker_level;
	logic busy_res;
	logic note_done;

	modport source (output valid, output speaker_level, output busy_res, output note_done,
		input ready);
	modport sink (input valid, input speaker_level, input busy_res, input note_done,
		output ready);
endinterface

@@ hw/rtl/note_tone_generator.sv @@
// ----------------------------------------------------------------------------
// note_tone_generator
// Square-wave speaker tone generator driven by start and tick requests.
// ----------------------------------------------------------------------------
// the result of an accepted request is registered and shows on res in the next cycle
// throughput: one request per cycle while res takes results; the single output register frees up
// in the same cycle its result is taken
// reset: arst_n clears the tone state and the output valid flag at once
module note_tone_generator #(
	parameter int unsigned FREQ_FRAC_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	ntg_req_if.sink  req,
	ntg_res_if.source res
);

	localparam int unsigned FQ_W = ntg_pkg::PERIODS_W + FREQ_FRAC_BITS;

	// fixed-point frequency table, floor(f * 2^frac), built at elaboration
	logic [FQ_W-1:0] freq_tab [ntg_pkg::NOTE_COUNT];

	for (genvar i = 0; i < ntg_pkg::NOTE_COUNT; i++) begin : g_freq
		localparam logic [63:0] FQ =
			(64'(ntg_pkg::MILLI_HZ_TAB[i]) << FREQ_FRAC_BITS) / 64'd1000;
		assign freq_tab[i] = FQ[FQ_W-1:0];
	end

	logic                              playing_q;
	logic                              rest_mode_q;
	logic [ntg_pkg::PERIODS_W-1:0]     periods_left_q;
	logic [ntg_pkg::HALF_W-1:0]        phase_q;
	logic [ntg_pkg::HALF_W-1:0]        half_period_q;
	logic                              level_q;

	logic                              res_valid_q;
	logic                              speaker_level_q;
	logic                              busy_res_q;
	logic                              note_done_q;

	logic                              accept;
	logic                              idx_ok;
	logic [ntg_pkg::IDX_W-1:0]         idx_safe;
	logic [FQ_W-1:0]                   fq;
	logic [FQ_W+1:0]                   fq3;
	logic [ntg_pkg::PERIODS_W-1:0]     k;
	logic [ntg_pkg::HALF_W-1:0]        hp;
	logic [ntg_pkg::HALF_W-1:0]        phase_dec;
	logic [ntg_pkg::PERIODS_W-1:0]     periods_dec;

	logic                              playing_d;
	logic                              rest_mode_d;
	logic [ntg_pkg::PERIODS_W-1:0]     periods_left_d;
	logic [ntg_pkg::HALF_W-1:0]        phase_d;
	logic [ntg_pkg::HALF_W-1:0]        half_period_d;
	logic                              level_d;
	logic                              done_d;

	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	// note lookup and period count for a start request
	assign idx_ok   = req.note_index <= ntg_pkg::REST_INDEX;
	assign idx_safe = idx_ok ? req.note_index : '0;
	assign fq       = freq_tab[idx_safe];
	assign fq3      = {2'b00, fq} + {1'b0, fq, 1'b0};
	assign hp       = idx_ok ? ntg_pkg::HALF_TAB[idx_safe] : '0;

	always_comb begin
		k = '0;
		if (idx_ok) begin
			unique case (ntg_pkg::duration_t'(req.duration_code))
				ntg_pkg::DUR_WHOLE:       k = fq[FQ_W-1:FREQ_FRAC_BITS];
				ntg_pkg::DUR_DOTTED_HALF: k = fq3[FQ_W+1:FREQ_FRAC_BITS+2];
				ntg_pkg::DUR_HALF:        k = ntg_pkg::PERIODS_W'(fq >> (FREQ_FRAC_BITS + 1));
				ntg_pkg::DUR_QUARTER:     k = ntg_pkg::PERIODS_W'(fq >> (FREQ_FRAC_BITS + 2));
				ntg_pkg::DUR_EIGHTH:      k = ntg_pkg::PERIODS_W'(fq >> (FREQ_FRAC_BITS + 3));
				default:                  k = '0;
			endcase
		end
	end

	assign phase_dec   = (phase_q != '0) ? phase_q - 1'b1 : '0;
	assign periods_dec = (periods_left_q != '0) ? periods_left_q - 1'b1 : '0;

	always_comb begin
		playing_d      = playing_q;
		rest_mode_d    = rest_mode_q;
		periods_left_d = periods_left_q;
		phase_d        = phase_q;
		half_period_d  = half_period_q;
		level_d        = level_q;
		done_d         = 1'b0;
		if (ntg_pkg::opcode_t'(req.opcode) == ntg_pkg::OP_START) begin
			half_period_d = hp;
			rest_mode_d   = (req.note_index == ntg_pkg::REST_INDEX);
			if (k == '0) begin
				playing_d      = 1'b0;
				level_d        = 1'b0;
				periods_left_d = '0;
				phase_d        = '0;
				done_d         = 1'b1;
			end else begin
				playing_d      = 1'b1;
				periods_left_d = k;
				level_d        = !rest_mode_d;
				phase_d        = rest_mode_d ? ntg_pkg::REST_TICKS : hp;
			end
		end else if (playing_q) begin
			phase_d = phase_dec;
			if (phase_dec == '0) begin
				if (!rest_mode_q && level_q) begin
					// end of the high half, go low for the second half
					level_d = 1'b0;
					phase_d = half_period_q;
				end else begin
					periods_left_d = periods_dec;
					if (periods_dec == '0) begin
						playing_d = 1'b0;
						level_d   = 1'b0;
						done_d    = 1'b1;
					end else begin
						level_d = !rest_mode_q;
						phase_d = rest_mode_q ? ntg_pkg::REST_TICKS : half_period_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q      <= 1'b0;
			rest_mode_q    <= 1'b0;
			periods_left_q <= '0;
			phase_q        <= '0;
			half_period_q  <= '0;
			level_q        <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				playing_q      <= playing_d;
				rest_mode_q    <= rest_mode_d;
				periods_left_q <= periods_left_d;
				phase_q        <= phase_d;
				half_period_q  <= half_period_d;
				level_q        <= level_d;
				res_valid_q    <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			speaker_level_q <= level_d;
			busy_res_q      <= playing_d;
			note_done_q     <= done_d;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.speaker_level = speaker_level_q;
	assign res.busy_res      = busy_res_q;
	assign res.note_done     = note_done_q;

`ifndef SYNTHESIS
	// a playing note always has ticks left in its current phase
	a_phase_live: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> phase_q != '0)
		else $error("playing with empty phase counter");

	// silence whenever nothing plays or a rest plays
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(!playing_q || rest_mode_q) |-> !level_q)
		else $error("speaker high while idle or resting");

	// a finished note is no longer busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && note_done_q) |-> !busy_res_q)
		else $error("note done while still busy");

	// a waiting result stays put until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> res_valid_q && $stable(speaker_level_q)
			&& $stable(busy_res_q) && $stable(note_done_q))
		else $error("result changed while stalled");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives start and tick requests into the note tone generator and checks
// every speaker level, busy and done flag against an in-bench tone model or
// fixed expected values, with and without random idling on both sides of the handshake.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned FRAC_BITS = 8;

	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_A_HI   = 5'd0;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_D_HI   = 5'd5;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_GS_HI  = 5'd11;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_A_LO   = 5'd12;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_D_LO   = 5'd17;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_GS_LO  = 5'd23;
	localparam logic [ntg_pkg::IDX_W-1:0] NOTE_REST   = ntg_pkg::REST_INDEX;
	localparam logic [ntg_pkg::IDX_W-1:0] IDX_BAD_LO  = 5'd25;
	localparam logic [ntg_pkg::IDX_W-1:0] IDX_BAD_HI  = 5'd31;
	localparam logic [ntg_pkg::DUR_W-1:0] DUR_BAD_LO  = 3'd5;
	localparam logic [ntg_pkg::DUR_W-1:0] DUR_BAD_MID = 3'd6;
	localparam logic [ntg_pkg::DUR_W-1:0] DUR_BAD_HI  = 3'd7;

	typedef struct packed {
		logic speaker_level;
		logic busy_res;
		logic note_done;
	} tone_res_t;

	localparam tone_res_t R_QUIET   = '{1'b0, 1'b0, 1'b0};
	localparam tone_res_t R_ENDED   = '{1'b0, 1'b0, 1'b1};
	localparam tone_res_t R_TONE_ON = '{1'b1, 1'b1, 1'b0};
	localparam tone_res_t R_REST_ON = '{1'b0, 1'b1, 1'b0};

	typedef struct {
		ntg_pkg::opcode_t          op;
		logic [ntg_pkg::IDX_W-1:0] idx;
		logic [ntg_pkg::DUR_W-1:0] dur;
		bit                        known;
		tone_res_t                 want;
	} stim_row_t;

	localparam int unsigned DIR_ROWS = 22;

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{ntg_pkg::OP_TICK,  NOTE_A_HI,  ntg_pkg::DUR_WHOLE,       1'b1, R_QUIET},
		'{ntg_pkg::OP_TICK,  IDX_BAD_HI, DUR_BAD_HI,               1'b1, R_QUIET},
		'{ntg_pkg::OP_START, IDX_BAD_LO, ntg_pkg::DUR_WHOLE,       1'b1, R_ENDED},
		'{ntg_pkg::OP_START, IDX_BAD_HI, DUR_BAD_HI,               1'b1, R_ENDED},
		'{ntg_pkg::OP_START, NOTE_A_HI,  DUR_BAD_LO,               1'b1, R_ENDED},
		'{ntg_pkg::OP_START, NOTE_A_HI,  DUR_BAD_HI,               1'b1, R_ENDED},
		'{ntg_pkg::OP_START, NOTE_A_HI,  ntg_pkg::DUR_WHOLE,       1'b1, R_TONE_ON},
		'{ntg_pkg::OP_TICK,  NOTE_A_HI,  ntg_pkg::DUR_WHOLE,       1'b0, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_REST,  ntg_pkg::DUR_EIGHTH,      1'b1, R_REST_ON},
		'{ntg_pkg::OP_TICK,  IDX_BAD_HI, DUR_BAD_HI,               1'b0, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_GS_HI, ntg_pkg::DUR_WHOLE,       1'b1, R_TONE_ON},
		'{ntg_pkg::OP_START, NOTE_A_LO,  ntg_pkg::DUR_DOTTED_HALF, 1'b1, R_TONE_ON},
		'{ntg_pkg::OP_TICK,  NOTE_A_LO,  ntg_pkg::DUR_QUARTER,     1'b0, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_GS_LO, ntg_pkg::DUR_HALF,        1'b1, R_TONE_ON},
		'{ntg_pkg::OP_START, NOTE_D_HI,  ntg_pkg::DUR_QUARTER,     1'b1, R_TONE_ON},
		'{ntg_pkg::OP_START, NOTE_D_LO,  ntg_pkg::DUR_EIGHTH,      1'b1, R_TONE_ON},
		'{ntg_pkg::OP_TICK,  IDX_BAD_LO, DUR_BAD_LO,               1'b0, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_REST,  ntg_pkg::DUR_WHOLE,       1'b1, R_REST_ON},
		'{ntg_pkg::OP_TICK,  NOTE_A_HI,  ntg_pkg::DUR_WHOLE,       1'b0, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_A_HI,  DUR_BAD_MID,              1'b1, R_ENDED},
		'{ntg_pkg::OP_TICK,  NOTE_GS_LO, ntg_pkg::DUR_EIGHTH,      1'b1, R_QUIET},
		'{ntg_pkg::OP_START, NOTE_REST,  DUR_BAD_LO,               1'b1, R_ENDED}
	};

	logic clk;
	logic arst_n;

	ntg_req_if req ();
	ntg_res_if res ();

	note_tone_generator #(
		.FREQ_FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	// tone model state
	bit                            tone_on;
	bit                            in_rest;
	bit                            lvl;
	logic [ntg_pkg::PERIODS_W-1:0] periods_left;
	logic [ntg_pkg::HALF_W-1:0]    phase_left;
	logic [ntg_pkg::HALF_W-1:0]    half_ticks;

	tone_res_t   tone_res_q [$];
	int unsigned mismatch_cnt = 0;
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_idle_pct  = 0;

	// period count of a note, frequency truncated to fixed point first
	function automatic logic [ntg_pkg::PERIODS_W-1:0] periods_for(
		logic [ntg_pkg::IDX_W-1:0] idx, logic [ntg_pkg::DUR_W-1:0] dur);
		logic [63:0] fq;
		logic [63:0] cnt;
		fq = ({32'd0, ntg_pkg::MILLI_HZ_TAB[idx]} << FRAC_BITS) / 64'd1000;
		case (dur)
			ntg_pkg::DUR_WHOLE:       cnt = fq >> FRAC_BITS;
			ntg_pkg::DUR_DOTTED_HALF: cnt = (fq * 64'd3) >> (FRAC_BITS + 2);
			ntg_pkg::DUR_HALF:        cnt = fq >> (FRAC_BITS + 1);
			ntg_pkg::DUR_QUARTER:     cnt = fq >> (FRAC_BITS + 2);
			ntg_pkg::DUR_EIGHTH:      cnt = fq >> (FRAC_BITS + 3);
			default:                  cnt = 64'd0;
		endcase
		return cnt[ntg_pkg::PERIODS_W-1:0];
	endfunction

	function automatic tone_res_t tone_step(ntg_pkg::opcode_t op,
		logic [ntg_pkg::IDX_W-1:0] idx, logic [ntg_pkg::DUR_W-1:0] dur);
		bit                            done;
		logic [ntg_pkg::PERIODS_W-1:0] cnt;
		done = 1'b0;
		cnt  = '0;
		if (op == ntg_pkg::OP_START) begin
			if (idx <= ntg_pkg::REST_INDEX) begin
				cnt        = periods_for(idx, dur);
				half_ticks = ntg_pkg::HALF_TAB[idx];
			end else begin
				half_ticks = '0;
			end
			in_rest = (idx == ntg_pkg::REST_INDEX);
			if (cnt == '0) begin
				tone_on      = 1'b0;
				lvl          = 1'b0;
				periods_left = '0;
				phase_left   = '0;
				done         = 1'b1;
			end else begin
				tone_on      = 1'b1;
				periods_left = cnt;
				lvl          = !in_rest;
				phase_left   = in_rest ? ntg_pkg::REST_TICKS : half_ticks;
			end
		end else if (tone_on) begin
			if (phase_left != '0)
				phase_left--;
			if (phase_left == '0) begin
				if (!in_rest && lvl) begin
					// second half of the period
					lvl        = 1'b0;
					phase_left = half_ticks;
				end else begin
					if (periods_left != '0)
						periods_left--;
					if (periods_left == '0) begin
						tone_on = 1'b0;
						lvl     = 1'b0;
						done    = 1'b1;
					end else begin
						lvl        = !in_rest;
						phase_left = in_rest ? ntg_pkg::REST_TICKS : half_ticks;
					end
				end
			end
		end
		return '{lvl, tone_on, done};
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_req(ntg_pkg::opcode_t op, logic [ntg_pkg::IDX_W-1:0] idx,
		logic [ntg_pkg::DUR_W-1:0] dur, bit known, tone_res_t want);
		tone_res_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.opcode        <= op;
		req.note_index    <= idx;
		req.duration_code <= dur;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		predicted = tone_step(op, idx, dur);
		tone_res_q.push_back(known ? want : predicted);
	endtask

	// tick fields other than the opcode are don't-care, so keep them random
	task automatic send_tick();
		send_req(ntg_pkg::OP_TICK, ntg_pkg::IDX_W'($urandom_range(IDX_BAD_HI)),
			ntg_pkg::DUR_W'($urandom_range(DUR_BAD_HI)), 1'b0, R_QUIET);
	endtask

	task automatic run_random(int unsigned budget);
		int unsigned               counted;
		int unsigned               nticks;
		logic [ntg_pkg::IDX_W-1:0] idx;
		logic [ntg_pkg::DUR_W-1:0] dur;
		counted = 0;
		while (counted < budget) begin
			idx = ($urandom_range(9) == 0)
				? ntg_pkg::IDX_W'($urandom_range(IDX_BAD_HI, IDX_BAD_LO))
				: ntg_pkg::IDX_W'($urandom_range(NOTE_REST));
			dur = ($urandom_range(9) == 0)
				? ntg_pkg::DUR_W'($urandom_range(DUR_BAD_HI, DUR_BAD_LO))
				: ntg_pkg::DUR_W'($urandom_range(ntg_pkg::DUR_EIGHTH));
			send_req(ntg_pkg::OP_START, idx, dur, 1'b0, R_QUIET);
			counted++;
			nticks = ($urandom_range(7) == 0) ? $urandom_range(400) : $urandom_range(60);
			repeat (nticks) begin
				send_tick();
				counted++;
			end
		end
	endtask

	// let a short note run out on ticks alone
	task automatic run_full_note();
		send_req(ntg_pkg::OP_START, ntg_pkg::IDX_W'($urandom_range(NOTE_REST)),
			ntg_pkg::DUR_EIGHTH, 1'b0, R_QUIET);
		while (tone_on)
			send_tick();
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (tone_res_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: check taken results, then pick the next ready
	initial begin
		tone_res_t want;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid === 1'b1 && res.ready) begin
				if (tone_res_q.size() == 0) begin
					$error("result with no request pending");
					mismatch_cnt++;
				end else begin
					want = tone_res_q.pop_front();
					if (res.speaker_level !== want.speaker_level) begin
						$error("speaker_level: expected %0b, got %0b", want.speaker_level,
							res.speaker_level);
						mismatch_cnt++;
					end
					if (res.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0b, got %0b", want.busy_res, res.busy_res);
						mismatch_cnt++;
					end
					if (res.note_done !== want.note_done) begin
						$error("note_done: expected %0b, got %0b", want.note_done,
							res.note_done);
						mismatch_cnt++;
					end
				end
			end
			res.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.opcode        = ntg_pkg::OP_TICK;
		req.note_index    = '0;
		req.duration_code = '0;
		tone_on           = 1'b0;
		in_rest           = 1'b0;
		lvl               = 1'b0;
		periods_left      = '0;
		phase_left        = '0;
		half_ticks        = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 22;
		rx_idle_pct = 59;
		for (int i = 0; i < DIR_ROWS; i++)
			send_req(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].dur, dir_tab[i].known,
				dir_tab[i].want);
		run_random(160);
		run_full_note();
		// hold the request side off until the result side catches up
		drain();

		tx_idle_pct = 59;
		rx_idle_pct = 22;
		run_random(160);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(160);
		drain();

		repeat (4) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
